// ----- sv/dacseq_pkg.sv -----
// ----------------------------------------------------------------------------
// dacseq_pkg
// Shared constants and types for the multi-DAC serial frame sequencer.
// ----------------------------------------------------------------------------
package dacseq_pkg;

  // Frame geometry.
  localparam int unsigned CHANNELS      = 128;
  localparam int unsigned SETUP_SAMPLES = 2;
  localparam int unsigned GAP_SAMPLES   = 2;
  localparam int unsigned BIT_SAMPLES   = 32;
  localparam int unsigned SLOT_SAMPLES  = SETUP_SAMPLES + BIT_SAMPLES + GAP_SAMPLES;
  localparam int unsigned FRAME_SAMPLES = CHANNELS * SLOT_SAMPLES;

  // Widths.
  localparam int unsigned CH_W      = $clog2(CHANNELS);
  localparam int unsigned OFF_W     = $clog2(SLOT_SAMPLES);
  localparam int unsigned POS_W     = $clog2(FRAME_SAMPLES);
  localparam int unsigned CHAN_IN_W = 7;
  localparam int unsigned LEVEL_W   = 12;
  localparam int unsigned MARK_W    = 8;
  localparam int unsigned PINS_W    = 8;
  localparam int unsigned WORD_W    = 16;

  // Reset code of every channel and reset frame mark length.
  localparam logic [LEVEL_W-1:0] DEFAULT_LEVEL = LEVEL_W'(3000);
  localparam logic [MARK_W-1:0]  DEFAULT_MARK  = MARK_W'(16);

  // Command codes.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Position of the sample that a tick plays.
  typedef struct packed {
    logic [CH_W-1:0]  chan;
    logic [OFF_W-1:0] offset;
    logic             mark;
  } slot_t;

endpackage

// ----- sv/dacseq_ram.sv -----
// ----------------------------------------------------------------------------
// dacseq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dacseq_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/dacseq_timing.sv -----
// ----------------------------------------------------------------------------
// dacseq_timing
// Frame position counters: channel slot, offset within the slot and the
// absolute sample position used for the frame mark.
// ----------------------------------------------------------------------------
module dacseq_timing (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic                          restart_i,
  input  logic [dacseq_pkg::MARK_W-1:0] mark_len_i,
  output dacseq_pkg::slot_t             slot_o
);

  logic [dacseq_pkg::CH_W-1:0]  chan_q, chan_d;
  logic [dacseq_pkg::OFF_W-1:0] off_q, off_d;
  logic [dacseq_pkg::POS_W-1:0] pos_q, pos_d;
  logic                         slot_end, frame_end;

  assign slot_end  = (off_q == dacseq_pkg::OFF_W'(dacseq_pkg::SLOT_SAMPLES - 1));
  assign frame_end = slot_end && (chan_q == dacseq_pkg::CH_W'(dacseq_pkg::CHANNELS - 1));

  // Next position: step by one sample, wrap at slot and frame ends.
  always_comb begin
    chan_d = chan_q;
    off_d  = off_q;
    pos_d  = pos_q;
    if (restart_i) begin
      chan_d = '0;
      off_d  = '0;
      pos_d  = '0;
    end else if (advance_i) begin
      if (frame_end) begin
        chan_d = '0;
        off_d  = '0;
        pos_d  = '0;
      end else if (slot_end) begin
        chan_d = chan_q + 1'b1;
        off_d  = '0;
        pos_d  = pos_q + 1'b1;
      end else begin
        off_d  = off_q + 1'b1;
        pos_d  = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
      off_q  <= '0;
      pos_q  <= '0;
    end else begin
      chan_q <= chan_d;
      off_q  <= off_d;
      pos_q  <= pos_d;
    end
  end

  // Current sample description.
  assign slot_o.chan   = chan_q;
  assign slot_o.offset = off_q;
  assign slot_o.mark   = (pos_q < dacseq_pkg::POS_W'(mark_len_i));

endmodule

// ----- sv/multi_dac_serial_frame_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// multi_dac_serial_frame_sequencer_top
// Refresh sequencer that streams the stored DAC codes as 8-bit pin words.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry cmd_i, channel_i, level_i and last_write_i on a
//   valid/ready channel. A tick beat (cmd 0) yields one pins_o beat on the
//   output valid/ready channel; a write beat (cmd 1) stores one channel code
//   and yields nothing, and with last_write_i set restarts the frame.
//   The frame mark length register is written through cfg_we_i/cfg_wdata_i.
//   A tick's pin word passes the channel-code RAM read, held in the read
//   stage, and then the output register before it shows on pins_o.
//   Throughput: one beat per cycle, tick or write, unless a stall holds
//   in_ready_o low; the RAM has a separate write and read port and each
//   beat uses only one of them.
//   A write followed right away by a tick of the same channel sees the new
//   code, since the read is issued after the write edge.
//   Reset: the frame position returns to zero, the frame mark length to 16
//   and every channel reads as 3000 through per-channel valid bits; no
//   clearing pass is needed, so beats are taken right after reset.
//   Stall: when the receiver holds out_ready_i low, the output register and
//   the read stage fill and in_ready_o drops after two pending words.
// ----------------------------------------------------------------------------
module multi_dac_serial_frame_sequencer_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             cmd_i,
  input  logic [dacseq_pkg::CHAN_IN_W-1:0] channel_i,
  input  logic [dacseq_pkg::LEVEL_W-1:0]   level_i,
  input  logic                             last_write_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [dacseq_pkg::PINS_W-1:0]    pins_o,
  input  logic                             cfg_we_i,
  input  logic [dacseq_pkg::MARK_W-1:0]    cfg_wdata_i
);

  logic                                accept, tick, wr, restart;
  logic [dacseq_pkg::MARK_W-1:0]       mark_len_q;
  logic [dacseq_pkg::CHANNELS-1:0]     lvl_valid_q;
  dacseq_pkg::slot_t                   slot;
  logic [dacseq_pkg::LEVEL_W-1:0]      rdata;
  logic                                s1_valid_q, s1_valid_d, s1_ready;
  dacseq_pkg::slot_t                   s1_slot_q;
  logic                                s1_lvl_valid_q;
  logic                                out_valid_q, out_ready_int;
  logic [dacseq_pkg::PINS_W-1:0]       pins_q, pins_c;

  // Handshake and command decode.
  assign out_ready_int = !out_valid_q || out_ready_i;
  assign s1_ready      = !s1_valid_q || out_ready_int;
  assign in_ready_o    = s1_ready;
  assign accept        = in_valid_i && in_ready_o;
  assign tick          = accept && (cmd_i == dacseq_pkg::CMD_TICK);
  assign wr            = accept && (cmd_i == dacseq_pkg::CMD_WRITE) &&
                         (32'(channel_i) < dacseq_pkg::CHANNELS);
  assign restart       = accept && (cmd_i == dacseq_pkg::CMD_WRITE) && last_write_i;

  // Frame mark length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_len_q <= dacseq_pkg::DEFAULT_MARK;
    end else if (cfg_we_i) begin
      mark_len_q <= cfg_wdata_i;
    end
  end

  // Position counters.
  dacseq_timing u_timing (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (tick),
    .restart_i  (restart),
    .mark_len_i (mark_len_q),
    .slot_o     (slot)
  );

  // Channel code store.
  dacseq_ram #(
    .WIDTH (dacseq_pkg::LEVEL_W),
    .DEPTH (dacseq_pkg::CHANNELS)
  ) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (wr),
    .waddr_i (channel_i[dacseq_pkg::CH_W-1:0]),
    .wdata_i (level_i),
    .re_i    (tick),
    .raddr_i (slot.chan),
    .rdata_o (rdata)
  );

  // Valid bits: an entry never written reads as the default code.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_valid_q <= '0;
    end else if (wr) begin
      lvl_valid_q[channel_i[dacseq_pkg::CH_W-1:0]] <= 1'b1;
    end
  end

  // Read stage: holds the sample description while the RAM read completes.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_ready) begin
      s1_valid_d = tick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      s1_slot_q      <= slot;
      s1_lvl_valid_q <= lvl_valid_q[slot.chan];
    end
  end

  // Pin word formatting.
  always_comb begin
    logic [dacseq_pkg::LEVEL_W-1:0]   level;
    logic [dacseq_pkg::CHAN_IN_W-1:0] chan7;
    logic [3:0]                       chip;
    logic [dacseq_pkg::WORD_W-1:0]    word;
    logic [dacseq_pkg::OFF_W-1:0]     k;
    logic                             in_bits, gap, mosi, sclk;
    level   = s1_lvl_valid_q ? rdata : dacseq_pkg::DEFAULT_LEVEL;
    chan7   = dacseq_pkg::CHAN_IN_W'(s1_slot_q.chan);
    chip    = chan7[6:3];
    word    = {1'b0, chan7[2:0], level};
    k       = s1_slot_q.offset - dacseq_pkg::OFF_W'(dacseq_pkg::SETUP_SAMPLES);
    in_bits = (s1_slot_q.offset >= dacseq_pkg::OFF_W'(dacseq_pkg::SETUP_SAMPLES)) &&
              (s1_slot_q.offset < dacseq_pkg::OFF_W'(dacseq_pkg::SETUP_SAMPLES +
                                                     dacseq_pkg::BIT_SAMPLES));
    gap     = (s1_slot_q.offset >= dacseq_pkg::OFF_W'(dacseq_pkg::SETUP_SAMPLES +
                                                      dacseq_pkg::BIT_SAMPLES));
    mosi    = in_bits && word[4'd15 - k[4:1]];
    sclk    = in_bits && !k[0];
    pins_c  = {s1_slot_q.mark, 1'b0, chip[1], chip[0], chip[3] ^ gap, chip[2], sclk, mosi};
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready_int) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_int && s1_valid_q) begin
      pins_q <= pins_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pins_o      = pins_q;

endmodule

// ----- sv/dacseq_checker.sv -----
// ----------------------------------------------------------------------------
// dacseq_checker
// Port-level checks for the multi-DAC serial frame sequencer.
// ----------------------------------------------------------------------------
module dacseq_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             cmd_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [dacseq_pkg::PINS_W-1:0]    pins_o
);

  // A stalled output beat holds its pin word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pins_o))
    else $error("output beat changed while stalled");

  // The LDAC pin stays low on every word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !pins_o[6])
    else $error("LDAC pin driven high");

  // Input backpressure only comes from a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // A tick passes the read stage and the output register when the receiver is ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (cmd_i == dacseq_pkg::CMD_TICK)) ##1 out_ready_i
      |=> out_valid_o)
    else $error("tick beat lost in the pipeline");

endmodule

bind multi_dac_serial_frame_sequencer_top dacseq_checker u_dacseq_checker (.*);
